### design/tspwm_pkg.sv
// Shared types, codes and tables of the two-sensor steering PWM controller.
package tspwm_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int CFG_BITS    = 10;
    localparam int WIN_BITS    = 6;
    localparam int CNT_BITS    = 7;
    localparam int MODE_BITS   = 3;
    localparam int CMD_BITS    = 8;
    localparam int IDX_BITS    = 3;
    localparam int LVL_BITS    = (SAMPLE_BITS > CFG_BITS ? SAMPLE_BITS : CFG_BITS) + 1;

    localparam logic [CNT_BITS-1:0] PWM_TOP = CNT_BITS'(100);

    // operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_CMD    = 2'd2;

    // register indexes
    localparam logic [IDX_BITS-1:0] CFG_REMOTE   = 3'd0;
    localparam logic [IDX_BITS-1:0] CFG_THR_L    = 3'd1;
    localparam logic [IDX_BITS-1:0] CFG_THR_R    = 3'd2;
    localparam logic [IDX_BITS-1:0] CFG_NEAR     = 3'd3;
    localparam logic [IDX_BITS-1:0] CFG_FAR      = 3'd4;
    localparam logic [IDX_BITS-1:0] CFG_FLOOR    = 3'd5;
    localparam logic [IDX_BITS-1:0] CFG_WINDOW   = 3'd6;

    // steering modes
    localparam logic [MODE_BITS-1:0] MODE_STOP    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_FWD     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_BACK    = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_TURN_LO = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_TURN_RO = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_TURN_LI = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_TURN_RI = 3'd6;

    // remote command bytes
    localparam logic [CMD_BITS-1:0] CMD_FWD   = 8'h46;
    localparam logic [CMD_BITS-1:0] CMD_BACK  = 8'h42;
    localparam logic [CMD_BITS-1:0] CMD_RIGHT = 8'h52;
    localparam logic [CMD_BITS-1:0] CMD_LEFT  = 8'h4C;

    typedef struct packed {
        logic [1:0]             op;
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
        logic [CMD_BITS-1:0]    command;
    } t_in_item;

    typedef struct packed {
        logic                 drive_a;
        logic                 drive_b;
        logic                 drive_c;
        logic                 drive_d;
        logic [MODE_BITS-1:0] steer_mode;
        logic                 decided;
    } t_out_item;

    typedef struct packed {
        logic [CFG_BITS-1:0] thr_left;
        logic [CFG_BITS-1:0] thr_right;
        logic [CFG_BITS-1:0] near_margin;
        logic [CFG_BITS-1:0] far_margin;
        logic [CFG_BITS-1:0] floor_level;
    } t_cls_cfg;

    typedef struct packed {
        logic                 hit;
        logic [MODE_BITS-1:0] mode;
    } t_cls_result;

    // duty per mode for outputs a..d
    function automatic logic [CNT_BITS-1:0] duty(input logic [MODE_BITS-1:0] mode,
                                                 input logic [1:0] chan);
        logic [4*CNT_BITS-1:0] row;
        row = '0;
        unique case (mode)
            MODE_FWD:     row = {7'd0,   7'd100, 7'd0,   7'd100};
            MODE_BACK:    row = {7'd100, 7'd0,   7'd100, 7'd0};
            MODE_TURN_LO: row = {7'd100, 7'd0,   7'd0,   7'd50};
            MODE_TURN_RO: row = {7'd0,   7'd50,  7'd100, 7'd0};
            MODE_TURN_LI: row = {7'd0,   7'd100, 7'd50,  7'd0};
            MODE_TURN_RI: row = {7'd50,  7'd0,   7'd0,   7'd100};
            default:      row = '0;
        endcase
        return row[(3 - chan) * CNT_BITS +: CNT_BITS];
    endfunction

endpackage

### design/two_sensor_steering_pwm_controller.sv
// Top level of the two-sensor steering PWM controller.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one transaction per
// item: a PWM tick, a sensor sample pair or a remote command byte, chosen by op.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
// transaction per item: the four PWM levels, the steering mode and a flag that
// is set when the item closed a peak window or applied a command.
// The configuration port writes one register per cycle with i_cfg_we high;
// write it only while no item is in flight.
// An item taken sits in the input register and then moves into the result
// register, which drives the output until the receiver takes it.
// Throughput: one item per cycle while the receiver does not stall; all the
// work of an item is one pass of compares and adds between those registers.
// Reset (i_rst_n low, synchronous) empties both stages, sets the registers to
// their defaults and clears counter, mode, peaks and window count.
// When the receiver stalls, the result register holds its transaction and the
// input register still takes one more item; after that o_in_ready drops.
module two_sensor_steering_pwm_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  tspwm_pkg::t_in_item                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output tspwm_pkg::t_out_item                 o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [tspwm_pkg::IDX_BITS-1:0]       i_cfg_index,
    input  logic [tspwm_pkg::CFG_BITS-1:0]       i_cfg_data
);
    localparam int SB = tspwm_pkg::SAMPLE_BITS;
    localparam int WB = tspwm_pkg::WIN_BITS;
    localparam int CB = tspwm_pkg::CNT_BITS;
    localparam int MB = tspwm_pkg::MODE_BITS;

    // configuration
    logic                r_remote;
    tspwm_pkg::t_cls_cfg r_cls_cfg;
    logic [WB-1:0]       r_window_len;

    // state
    logic [CB-1:0] r_counter, n_counter;
    logic [MB-1:0] r_mode, n_mode;
    logic [SB-1:0] r_peak_left, n_peak_left;
    logic [SB-1:0] r_peak_right, n_peak_right;
    logic [WB-1:0] r_window_count, n_window_count;

    // pipeline
    logic                 r_in_valid;
    tspwm_pkg::t_in_item  r_in;
    logic                 r_out_valid;
    tspwm_pkg::t_out_item r_out, n_out;
    logic                 out_adv, item_go;

    logic [SB-1:0]          max_left, max_right;
    logic [WB-1:0]          count_inc, win_len;
    logic                   decided;
    tspwm_pkg::t_cls_result cls;
    logic [3:0]             levels;

    assign out_adv     = !r_out_valid || i_out_ready;
    assign item_go     = r_in_valid && out_adv;
    assign o_in_ready  = !r_in_valid || out_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remote              <= 1'b0;
            r_cls_cfg.thr_left    <= 10'd248;
            r_cls_cfg.thr_right   <= 10'd248;
            r_cls_cfg.near_margin <= 10'd31;
            r_cls_cfg.far_margin  <= 10'd62;
            r_cls_cfg.floor_level <= 10'd31;
            r_window_len          <= 6'd30;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tspwm_pkg::CFG_REMOTE: r_remote              <= i_cfg_data[0];
                tspwm_pkg::CFG_THR_L:  r_cls_cfg.thr_left    <= i_cfg_data;
                tspwm_pkg::CFG_THR_R:  r_cls_cfg.thr_right   <= i_cfg_data;
                tspwm_pkg::CFG_NEAR:   r_cls_cfg.near_margin <= i_cfg_data;
                tspwm_pkg::CFG_FAR:    r_cls_cfg.far_margin  <= i_cfg_data;
                tspwm_pkg::CFG_FLOOR:  r_cls_cfg.floor_level <= i_cfg_data;
                tspwm_pkg::CFG_WINDOW: r_window_len          <= i_cfg_data[WB-1:0];
                default: ;
            endcase
        end
    end

    tspwm_classify u_classify (
        .i_peak_left  (max_left),
        .i_peak_right (max_right),
        .i_cfg        (r_cls_cfg),
        .o_result     (cls)
    );

    tspwm_duty u_duty (
        .i_counter (n_counter),
        .i_mode    (n_mode),
        .o_levels  (levels)
    );

    always_comb begin
        max_left  = (r_in.left_sample > r_peak_left) ? r_in.left_sample : r_peak_left;
        max_right = (r_in.right_sample > r_peak_right) ? r_in.right_sample : r_peak_right;
        count_inc = r_window_count + 1'b1;
        win_len   = (r_window_len == '0) ? WB'(1) : r_window_len;

        n_counter      = r_counter;
        n_mode         = r_mode;
        n_peak_left    = r_peak_left;
        n_peak_right   = r_peak_right;
        n_window_count = r_window_count;
        decided        = 1'b0;

        unique case (r_in.op)
            tspwm_pkg::OP_TICK: begin
                n_counter = (r_counter >= tspwm_pkg::PWM_TOP) ? '0 : r_counter + 1'b1;
            end
            tspwm_pkg::OP_SAMPLE: begin
                if (!r_remote) begin
                    if (count_inc >= win_len) begin
                        // close the window: decide, then start fresh peaks
                        if (cls.hit) begin
                            n_mode = cls.mode;
                        end
                        n_peak_left    = '0;
                        n_peak_right   = '0;
                        n_window_count = '0;
                        decided        = 1'b1;
                    end else begin
                        n_peak_left    = max_left;
                        n_peak_right   = max_right;
                        n_window_count = count_inc;
                    end
                end
            end
            tspwm_pkg::OP_CMD: begin
                if (r_remote) begin
                    unique case (r_in.command)
                        tspwm_pkg::CMD_FWD:   n_mode = tspwm_pkg::MODE_FWD;
                        tspwm_pkg::CMD_BACK:  n_mode = tspwm_pkg::MODE_BACK;
                        tspwm_pkg::CMD_RIGHT: n_mode = tspwm_pkg::MODE_TURN_LI;
                        tspwm_pkg::CMD_LEFT:  n_mode = tspwm_pkg::MODE_TURN_RI;
                        default:              n_mode = tspwm_pkg::MODE_STOP;
                    endcase
                    decided = 1'b1;
                end
            end
            default: ;
        endcase

        n_out.drive_a    = levels[3];
        n_out.drive_b    = levels[2];
        n_out.drive_c    = levels[1];
        n_out.drive_d    = levels[0];
        n_out.steer_mode = n_mode;
        n_out.decided    = decided;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_counter      <= '0;
            r_mode         <= tspwm_pkg::MODE_STOP;
            r_peak_left    <= '0;
            r_peak_right   <= '0;
            r_window_count <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (item_go) begin
                r_counter      <= n_counter;
                r_mode         <= n_mode;
                r_peak_left    <= n_peak_left;
                r_peak_right   <= n_peak_right;
                r_window_count <= n_window_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (item_go) begin
            r_out <= n_out;
        end
    end

    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counter <= tspwm_pkg::PWM_TOP)
        else $error("PWM counter beyond top");

    a_mode_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.steer_mode != 3'd7)
        else $error("unreachable steering mode on output");

    a_window_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_go && decided && r_in.op == tspwm_pkg::OP_SAMPLE) |=>
        (r_window_count == '0 && r_peak_left == '0 && r_peak_right == '0))
        else $error("peaks not cleared after window decision");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !item_go |=> $stable(r_counter) && $stable(r_mode) && $stable(r_window_count))
        else $error("state changed without an item");
endmodule

### design/tspwm_classify.sv
// Window decision: sorts the left and right peaks into a steering mode.
module tspwm_classify (
    input  logic [tspwm_pkg::SAMPLE_BITS-1:0] i_peak_left,
    input  logic [tspwm_pkg::SAMPLE_BITS-1:0] i_peak_right,
    input  tspwm_pkg::t_cls_cfg               i_cfg,
    output tspwm_pkg::t_cls_result            o_result
);
    localparam int W = tspwm_pkg::LVL_BITS;

    logic [W-1:0] l, r, tl, tr, nm, fm, fl;
    logic both_high, l_low, r_low, l_high, r_high, l_seen, r_seen;

    always_comb begin
        l  = W'(i_peak_left);
        r  = W'(i_peak_right);
        tl = W'(i_cfg.thr_left);
        tr = W'(i_cfg.thr_right);
        nm = W'(i_cfg.near_margin);
        fm = W'(i_cfg.far_margin);
        fl = W'(i_cfg.floor_level);

        both_high = (l > tl + nm) && (r > tr + nm);
        // peak below threshold minus margin, kept unsigned by moving the margin over
        l_low  = (l + fm) < tl;
        r_low  = (r + fm) < tr;
        l_high = l > tl + fm;
        r_high = r > tr + fm;
        l_seen = l > fl;
        r_seen = r > fl;

        o_result.hit  = 1'b1;
        o_result.mode = tspwm_pkg::MODE_STOP;
        priority if (both_high) begin
            o_result.mode = tspwm_pkg::MODE_BACK;
        end else if (l_low && r_low && l_seen && r_seen) begin
            o_result.mode = tspwm_pkg::MODE_FWD;
        end else if (!l_seen && !r_seen) begin
            o_result.mode = tspwm_pkg::MODE_STOP;
        end else if (l_low) begin
            o_result.mode = tspwm_pkg::MODE_TURN_LO;
        end else if (r_low) begin
            o_result.mode = tspwm_pkg::MODE_TURN_RO;
        end else if (l_high) begin
            o_result.mode = tspwm_pkg::MODE_TURN_LI;
        end else if (r_high) begin
            o_result.mode = tspwm_pkg::MODE_TURN_RI;
        end else begin
            o_result.hit = 1'b0;
        end
    end
endmodule

### design/tspwm_duty.sv
// PWM compare: four output levels from the counter and the mode's duty row.
module tspwm_duty (
    input  logic [tspwm_pkg::CNT_BITS-1:0]  i_counter,
    input  logic [tspwm_pkg::MODE_BITS-1:0] i_mode,
    output logic [3:0]                      o_levels
);
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_levels[3 - k] = i_counter <= tspwm_pkg::duty(i_mode, 2'(k));
        end
    end
endmodule

### sim/two_sensor_steering_pwm_controller_tb.sv
// Self-checking testbench of the two-sensor steering PWM controller.
`timescale 1ns / 100ps

module two_sensor_steering_pwm_controller_tb;
    import tspwm_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;

    // duty in percent per mode, outputs a..d
    localparam logic [0:7][0:3][CNT_BITS-1:0] DUTY_PCT = {
        7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd100, 7'd0,   7'd100,
        7'd100, 7'd0,   7'd100, 7'd0,
        7'd100, 7'd0,   7'd0,   7'd50,
        7'd0,   7'd50,  7'd100, 7'd0,
        7'd0,   7'd100, 7'd50,  7'd0,
        7'd50,  7'd0,   7'd0,   7'd100,
        7'd0,   7'd0,   7'd0,   7'd0
    };

    typedef struct packed {
        logic                remote;
        logic [CFG_BITS-1:0] thr_l;
        logic [CFG_BITS-1:0] thr_r;
        logic [CFG_BITS-1:0] near_m;
        logic [CFG_BITS-1:0] far_m;
        logic [CFG_BITS-1:0] floor_l;
        logic [WIN_BITS-1:0] win;
    } t_setup;

    localparam t_setup DEFAULT_SETUP = '{remote: 1'b0, thr_l: 10'd248, thr_r: 10'd248,
                                         near_m: 10'd31, far_m: 10'd62, floor_l: 10'd31,
                                         win: 6'd30};

    typedef struct {
        int        setup_id;
        t_in_item  item;
        bit        lit_on;
        t_out_item lit;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_data;
    logic                i_cfg_we = 1'b0;
    logic [IDX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_BITS-1:0] i_cfg_data = '0;

    two_sensor_steering_pwm_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    t_setup                regs = DEFAULT_SETUP;
    logic [CNT_BITS-1:0]   pwm_pos = '0;
    logic [MODE_BITS-1:0]  steer = MODE_STOP;
    logic [SAMPLE_BITS-1:0] peak_l = '0;
    logic [SAMPLE_BITS-1:0] peak_r = '0;
    logic [WIN_BITS-1:0]   pairs_seen = '0;

    t_out_item predicted_steer [$];
    t_row      dir_rows [$];

    int errors = 0;
    int n_ticks = 0, n_pairs = 0, n_cmds = 0, n_decided = 0, n_settings = 0, n_items = 0;
    int burst_left = 0;
    bit steady = 1'b0;
    int stall_style = 0, stall_left = 0, rx_cycle = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic t_out_item next_steer(input t_in_item it);
        logic [CNT_BITS-1:0] step_pos;
        logic [WIN_BITS-1:0] span;
        int l, r, tl, tr, nm, fm, fl;
        t_out_item res;
        res = '0;
        case (it.op)
            OP_TICK: begin
                step_pos = pwm_pos + 1'b1;
                pwm_pos = (step_pos > PWM_TOP) ? '0 : step_pos;
            end
            OP_SAMPLE: if (!regs.remote) begin
                span = (regs.win == '0) ? WIN_BITS'(1) : regs.win;
                if (it.left_sample > peak_l) peak_l = it.left_sample;
                if (it.right_sample > peak_r) peak_r = it.right_sample;
                pairs_seen = pairs_seen + 1'b1;
                if (pairs_seen >= span) begin
                    l = int'(peak_l);
                    r = int'(peak_r);
                    tl = int'(regs.thr_l);
                    tr = int'(regs.thr_r);
                    nm = int'(regs.near_m);
                    fm = int'(regs.far_m);
                    fl = int'(regs.floor_l);
                    // first match wins; no match keeps the last mode
                    if (l > tl + nm && r > tr + nm) steer = MODE_BACK;
                    else if (l < tl - fm && r < tr - fm && l > fl && r > fl) steer = MODE_FWD;
                    else if (l <= fl && r <= fl) steer = MODE_STOP;
                    else if (l < tl - fm) steer = MODE_TURN_LO;
                    else if (r < tr - fm) steer = MODE_TURN_RO;
                    else if (l > tl + fm) steer = MODE_TURN_LI;
                    else if (r > tr + fm) steer = MODE_TURN_RI;
                    peak_l = '0;
                    peak_r = '0;
                    pairs_seen = '0;
                    res.decided = 1'b1;
                end
            end
            OP_CMD: if (regs.remote) begin
                case (it.command)
                    CMD_FWD:   steer = MODE_FWD;
                    CMD_BACK:  steer = MODE_BACK;
                    CMD_RIGHT: steer = MODE_TURN_LI;
                    CMD_LEFT:  steer = MODE_TURN_RI;
                    default:   steer = MODE_STOP;
                endcase
                res.decided = 1'b1;
            end
            default: ;
        endcase
        res.drive_a = pwm_pos <= DUTY_PCT[steer][0];
        res.drive_b = pwm_pos <= DUTY_PCT[steer][1];
        res.drive_c = pwm_pos <= DUTY_PCT[steer][2];
        res.drive_d = pwm_pos <= DUTY_PCT[steer][3];
        res.steer_mode = steer;
        return res;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] around(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return SAMPLE_BITS'(v);
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int pick, spread;
        it.left_sample = SAMPLE_BITS'($urandom_range(0, 1023));
        it.right_sample = SAMPLE_BITS'($urandom_range(0, 1023));
        it.command = CMD_BITS'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 35) it.op = OP_TICK;
        else if (pick < (regs.remote ? 45 : 85)) it.op = OP_SAMPLE;
        else if (pick < 95) it.op = OP_CMD;
        else it.op = OP_NONE;
        // keep most samples near the decision levels
        if ($urandom_range(0, 3) != 0) begin
            spread = int'(regs.far_m) + int'(regs.near_m) + 16;
            it.left_sample = ($urandom_range(0, 4) == 0) ? around(int'(regs.floor_l), 8)
                                                        : around(int'(regs.thr_l), spread);
            it.right_sample = ($urandom_range(0, 4) == 0) ? around(int'(regs.floor_l), 8)
                                                         : around(int'(regs.thr_r), spread);
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0:       it.command = CMD_FWD;
                1:       it.command = CMD_BACK;
                2:       it.command = CMD_RIGHT;
                default: it.command = CMD_LEFT;
            endcase
        end
        return it;
    endfunction

    function automatic t_setup random_setup();
        t_setup s;
        int pick;
        s.remote = ($urandom_range(0, 4) == 0);
        s.thr_l = CFG_BITS'($urandom_range(100, 500));
        s.thr_r = CFG_BITS'($urandom_range(100, 500));
        s.near_m = CFG_BITS'($urandom_range(0, 80));
        s.far_m = CFG_BITS'($urandom_range(0, 150));
        s.floor_l = CFG_BITS'($urandom_range(0, 120));
        pick = $urandom_range(0, 9);
        if (pick == 0) s.win = '0;
        else if (pick == 1) s.win = '1;
        else s.win = WIN_BITS'($urandom_range(1, 8));
        return s;
    endfunction

    task automatic add_row(input int setup_id, input logic [1:0] op, input int ls, input int rs,
                           input int cmd, input int lit_on, input logic [3:0] drv,
                           input logic [MODE_BITS-1:0] md, input logic dec);
        t_row rw;
        rw.setup_id = setup_id;
        rw.item = '{op: op, left_sample: SAMPLE_BITS'(ls), right_sample: SAMPLE_BITS'(rs),
                    command: CMD_BITS'(cmd)};
        rw.lit_on = (lit_on != 0);
        rw.lit = '{drive_a: drv[3], drive_b: drv[2], drive_c: drv[1], drive_d: drv[0],
                   steer_mode: md, decided: dec};
        dir_rows.push_back(rw);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input t_setup s);
        write_reg(CFG_REMOTE, CFG_BITS'(s.remote));
        write_reg(CFG_THR_L, s.thr_l);
        write_reg(CFG_THR_R, s.thr_r);
        write_reg(CFG_NEAR, s.near_m);
        write_reg(CFG_FAR, s.far_m);
        write_reg(CFG_FLOOR, s.floor_l);
        write_reg(CFG_WINDOW, CFG_BITS'(s.win));
        i_cfg_we <= 1'b0;
        regs = s;
        n_settings++;
    endtask

    // drain the pipeline before touching the registers
    task automatic settle();
        i_in_valid <= 1'b0;
        while (predicted_steer.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_item(input t_in_item it, input bit lit_on, input t_out_item lit);
        int gap;
        t_out_item exp_item;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        exp_item = next_steer(it);
        predicted_steer.push_back(lit_on ? lit : exp_item);
        n_items++;
        if (it.op == OP_TICK) n_ticks++;
        if (it.op == OP_SAMPLE) n_pairs++;
        if (it.op == OP_CMD) n_cmds++;
        if (exp_item.decided) n_decided++;
    endtask

    task automatic check_field(input string name, input logic [2:0] want_v,
                               input logic [2:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_steer.size() == 0) begin
                $error("result transaction with nothing pending: %p", o_out_data);
                errors++;
            end else begin
                want = predicted_steer.pop_front();
                check_field("drive_a", 3'(want.drive_a), 3'(o_out_data.drive_a));
                check_field("drive_b", 3'(want.drive_b), 3'(o_out_data.drive_b));
                check_field("drive_c", 3'(want.drive_c), 3'(o_out_data.drive_c));
                check_field("drive_d", 3'(want.drive_d), 3'(o_out_data.drive_d));
                check_field("steer_mode", want.steer_mode, o_out_data.steer_mode);
                check_field("decided", 3'(want.decided), 3'(o_out_data.decided));
            end
        end
    end

    // receiver: switch at random between stall styles
    always @(posedge i_clk) begin
        rx_cycle++;
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end else begin
            stall_left--;
        end
        case (stall_style)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 9) < 7);
            2:       i_out_ready <= ($urandom_range(0, 9) < 3);
            default: i_out_ready <= (rx_cycle % 5) != 0;
        endcase
    end

    initial begin
        t_row rw;
        t_setup s;
        int ph;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: counter 0, stop
        add_row(0, OP_NONE,   0,    0,    0,         1, 4'b1111, MODE_STOP,    1'b0);
        add_row(0, OP_TICK,   1023, 1023, 255,       1, 4'b0000, MODE_STOP,    1'b0);
        add_row(0, OP_CMD,    0,    0,    CMD_FWD,   1, 4'b0000, MODE_STOP,    1'b0);
        add_row(0, OP_SAMPLE, 1023, 1023, 0,         1, 4'b0000, MODE_STOP,    1'b0);
        // remote mode, counter at 1
        add_row(1, OP_CMD,    0,    0,    CMD_FWD,   1, 4'b0101, MODE_FWD,     1'b1);
        add_row(0, OP_CMD,    0,    0,    CMD_BACK,  1, 4'b1010, MODE_BACK,    1'b1);
        add_row(0, OP_CMD,    0,    0,    CMD_RIGHT, 1, 4'b0110, MODE_TURN_LI, 1'b1);
        add_row(0, OP_CMD,    0,    0,    CMD_LEFT,  1, 4'b1001, MODE_TURN_RI, 1'b1);
        add_row(0, OP_CMD,    0,    0,    255,       1, 4'b0000, MODE_STOP,    1'b1);
        add_row(0, OP_CMD,    0,    0,    0,         1, 4'b0000, MODE_STOP,    1'b1);
        add_row(0, OP_SAMPLE, 500,  500,  0,         1, 4'b0000, MODE_STOP,    1'b0);
        // sensor mode with a zero window: every pair decides
        add_row(2, OP_SAMPLE, 1023, 1023, 0,   0, '0, MODE_STOP, 1'b0);
        add_row(0, OP_SAMPLE, 0,    0,    0,   0, '0, MODE_STOP, 1'b0);
        add_row(0, OP_SAMPLE, 100,  100,  0,   0, '0, MODE_STOP, 1'b0);
        add_row(0, OP_SAMPLE, 100,  248,  0,   0, '0, MODE_STOP, 1'b0);
        add_row(0, OP_SAMPLE, 248,  100,  0,   0, '0, MODE_STOP, 1'b0);
        add_row(0, OP_SAMPLE, 400,  248,  0,   0, '0, MODE_STOP, 1'b0);
        add_row(0, OP_SAMPLE, 248,  400,  0,   0, '0, MODE_STOP, 1'b0);
        add_row(0, OP_SAMPLE, 248,  248,  0,   0, '0, MODE_STOP, 1'b0);
        add_row(0, OP_CMD,    0,    0,    CMD_BACK, 0, '0, MODE_STOP, 1'b0);
        add_row(0, OP_TICK,   0,    0,    0,   0, '0, MODE_STOP, 1'b0);
        add_row(0, OP_NONE,   1023, 1023, 255, 0, '0, MODE_STOP, 1'b0);

        foreach (dir_rows[k]) begin
            rw = dir_rows[k];
            if (rw.setup_id != 0) begin
                settle();
                s = DEFAULT_SETUP;
                if (rw.setup_id == 1) s.remote = 1'b1;
                else s.win = '0;
                load_settings(s);
            end
            send_item(rw.item, rw.lit_on, rw.lit);
        end

        for (ph = 0; ph < 10; ph++) begin
            settle();
            case (ph)
                0: s = DEFAULT_SETUP;
                1: s = '0;
                2: begin
                    s = '1;
                    s.remote = 1'b0;
                end
                3: s = '1;
                default: s = random_setup();
            endcase
            steady = (ph % 3 == 1);
            load_settings(s);
            repeat (130) send_item(random_item(), 1'b0, '0);
        end
        settle();

        $display("run covered %0d items: %0d ticks, %0d sample pairs, %0d command bytes",
                 n_items, n_ticks, n_pairs, n_cmds);
        $display("%0d windows closed or commands applied across %0d register settings",
                 n_decided, n_settings);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
design/tspwm_pkg.sv
design/tspwm_classify.sv
design/tspwm_duty.sv
design/two_sensor_steering_pwm_controller.sv
sim/two_sensor_steering_pwm_controller_tb.sv
